@@ design/skf_pkg.sv @@
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants for the scalar Kalman filter: default widths, the
// configuration register map and the reset value of the noise registers.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int DATA_WIDTH_DEF     = 32;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int REG_WIDTH       = 32;
    localparam int REG_INDEX_WIDTH = 2;

    localparam logic [REG_INDEX_WIDTH-1:0] REG_PROCESS_NOISE     = REG_INDEX_WIDTH'(0);
    localparam logic [REG_INDEX_WIDTH-1:0] REG_MEASUREMENT_NOISE = REG_INDEX_WIDTH'(1);

    localparam logic [REG_WIDTH-1:0] NOISE_RESET = REG_WIDTH'(65536);

endpackage

@@ design/skf_gain_div.sv @@
// ----------------------------------------------------------------------------
// skf_gain_div
// Restoring divider that forms floor(num * 2^QUO_WIDTH / den) for num < den
// (all ones for num == den), one quotient bit per cycle. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module skf_gain_div #(
    parameter int NUM_WIDTH = 32,
    parameter int DEN_WIDTH = 33,
    parameter int QUO_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_WIDTH-1:0] i_num,
    input  logic [DEN_WIDTH-1:0] i_den,
    output logic                 o_done,
    output logic [QUO_WIDTH-1:0] o_quo
);

    localparam int CNT_WIDTH = $clog2(QUO_WIDTH + 1);

    logic [DEN_WIDTH-1:0] r_rem;
    logic [DEN_WIDTH-1:0] r_den;
    logic [QUO_WIDTH-1:0] r_quo;
    logic                 r_den_zero;
    logic [CNT_WIDTH-1:0] r_count;
    logic                 r_busy;
    logic                 r_done;

    logic [DEN_WIDTH:0]   n_shift;
    logic [DEN_WIDTH:0]   n_diff;
    logic                 n_fits;
    logic [DEN_WIDTH-1:0] n_rem;

    always_comb begin
        n_shift = {r_rem, 1'b0};
        n_diff  = n_shift - {1'b0, r_den};
        n_fits  = n_shift >= {1'b0, r_den};
        n_rem   = n_fits ? n_diff[DEN_WIDTH-1:0] : n_shift[DEN_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_WIDTH'(QUO_WIDTH);
            end else if (r_busy) begin
                r_count <= r_count - CNT_WIDTH'(1);
                if (r_count == CNT_WIDTH'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem      <= DEN_WIDTH'(i_num);
            r_den      <= i_den;
            r_quo      <= '0;
            r_den_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_WIDTH-2:0], n_fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_den_zero ? '0 : r_quo;

endmodule

@@ design/scalar_kalman_filter.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter on Q16.16 data with a serial gain divider and
// bit-serial multipliers for the correction and the variance update.
//
//   Channel       Direction  Handshake                 Payload
//   measurement   in         i_in_valid / o_in_stall   i_measurement
//   result        out        o_out_valid / i_out_stall o_estimate, o_gain
//   configuration in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// After acceptance a request passes the serial divider and then the multipliers, one bit
// per cycle each, and its result is written to the output register once that is free; the
// next request can be taken in the cycle after that write.
// One request is in work at a time; a finished result waits in the output register
// while the next request is taken. Reset is synchronous and sets both noise registers
// to 1.0 and the estimate and variance to zero.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
    parameter int DATA_WIDTH     = skf_pkg::DATA_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = skf_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]        i_measurement,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [DATA_WIDTH-1:0]        o_estimate,
    output logic [GAIN_FRAC_BITS-1:0]           o_gain,
    input  logic                                i_cfg_we,
    input  logic [skf_pkg::REG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [skf_pkg::REG_WIDTH-1:0]       i_cfg_data
);

    localparam int W         = DATA_WIDTH;
    localparam int F         = GAIN_FRAC_BITS;
    localparam int SUM_WIDTH = (W > skf_pkg::REG_WIDTH ? W : skf_pkg::REG_WIDTH) + 1;
    localparam int CNT_WIDTH = $clog2(F + 1);
    localparam logic [W+F:0] ROUND_HALF = (W + F + 1)'(1) << (F - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_MUL,
        S_CORR,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [skf_pkg::REG_WIDTH-1:0] r_q;
    logic [skf_pkg::REG_WIDTH-1:0] r_r;
    logic [W-1:0]           r_last_est;
    logic [W-1:0]           r_last_var;
    logic [W-1:0]           r_meas;
    logic [W-1:0]           r_pred;
    logic [W:0]             r_mag;
    logic                   r_neg;
    logic [F-1:0]           r_gain;
    logic [F-1:0]           r_mbits;
    logic [CNT_WIDTH-1:0]   r_count;
    logic [W+F:0]           r_acc_c;
    logic [W+F-1:0]         r_acc_v;
    logic [W:0]             r_corr;
    logic [W-1:0]           r_var;
    logic                   r_out_valid;
    logic [W-1:0]           r_out_est;
    logic [F-1:0]           r_out_gain;

    logic                   n_in_accept;
    logic                   n_out_free;
    logic [SUM_WIDTH-1:0]   n_pred_sum;
    logic [W-1:0]           n_pred;
    logic [SUM_WIDTH-1:0]   n_den;
    logic [W:0]             n_diff;
    logic [W:0]             n_mag;
    logic [W+1:0]           n_sum_c;
    logic [W:0]             n_sum_v;
    logic [W+F:0]           n_round;
    logic [W+F-1:0]         n_var_full;
    logic [W+1:0]           n_est_sum;
    logic [W-1:0]           n_est;
    logic                   n_div_start;
    logic                   w_div_done;
    logic [F-1:0]           w_div_quo;

    always_comb begin
        n_in_accept = i_in_valid && (r_state == S_IDLE);
        n_out_free  = !r_out_valid || !i_out_stall;

        n_pred_sum = SUM_WIDTH'(r_last_var) + SUM_WIDTH'(r_q);
        n_pred     = ((n_pred_sum >> W) != '0) ? '1 : n_pred_sum[W-1:0];
        n_den      = SUM_WIDTH'(r_pred) + SUM_WIDTH'(r_r);

        n_diff = {r_meas[W-1], r_meas} - {r_last_est[W-1], r_last_est};
        n_mag  = n_diff[W] ? (~n_diff + (W + 1)'(1)) : n_diff;

        n_sum_c = {1'b0, r_acc_c[W+F:F]} + (r_mbits[0] ? {1'b0, r_mag} : '0);
        n_sum_v = {1'b0, r_acc_v[W+F-1:F]} + (r_mbits[0] ? {1'b0, r_pred} : '0);

        n_round    = r_acc_c + ROUND_HALF;
        n_var_full = {r_pred, {F{1'b0}}} - r_acc_v;

        n_est_sum = r_neg ? ({{2{r_last_est[W-1]}}, r_last_est} - {1'b0, r_corr})
                          : ({{2{r_last_est[W-1]}}, r_last_est} + {1'b0, r_corr});
        if (n_est_sum[W+1] != n_est_sum[W] || n_est_sum[W] != n_est_sum[W-1]) begin
            n_est = n_est_sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            n_est = n_est_sum[W-1:0];
        end

        n_div_start = (r_state == S_START);
    end

    skf_gain_div #(
        .NUM_WIDTH (W),
        .DEN_WIDTH (SUM_WIDTH),
        .QUO_WIDTH (F)
    ) u_gain_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (r_pred),
        .i_den   (n_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_q         <= skf_pkg::NOISE_RESET;
            r_r         <= skf_pkg::NOISE_RESET;
            r_last_est  <= '0;
            r_last_var  <= '0;
            r_count     <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_in_accept) begin
                        r_meas  <= i_measurement;
                        r_pred  <= n_pred;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_mag   <= n_mag;
                    r_neg   <= n_diff[W];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_gain  <= w_div_quo;
                        r_mbits <= w_div_quo;
                        r_acc_c <= '0;
                        r_acc_v <= '0;
                        r_count <= CNT_WIDTH'(F);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc_c <= {n_sum_c, r_acc_c[F-1:1]};
                    r_acc_v <= {n_sum_v, r_acc_v[F-1:1]};
                    r_mbits <= r_mbits >> 1;
                    r_count <= r_count - CNT_WIDTH'(1);
                    if (r_count == CNT_WIDTH'(1)) begin
                        r_state <= S_CORR;
                    end
                end
                S_CORR: begin
                    r_corr  <= n_round[W+F:F];
                    r_var   <= n_var_full[W+F-1:F];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_out_est   <= n_est;
                        r_out_gain  <= r_gain;
                        r_out_valid <= 1'b1;
                        r_last_est  <= n_est;
                        r_last_var  <= r_var;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    skf_pkg::REG_PROCESS_NOISE: begin
                        r_q        <= i_cfg_data;
                        r_last_est <= '0;
                        r_last_var <= '0;
                    end
                    skf_pkg::REG_MEASUREMENT_NOISE: begin
                        r_r        <= i_cfg_data;
                        r_last_est <= '0;
                        r_last_var <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_out_est;
    assign o_gain      = r_out_gain;

endmodule

@@ tb/tb_scalar_kalman_filter.sv @@
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter
// Self-checking bench for the scalar Kalman filter. A bit-exact predictor of
// the filter tracks every accepted request and queues the estimate and gain
// it should produce. A checker compares each delivered result with the oldest
// queued one. Directed tests cover reset values, extreme measurements, gain
// saturation, a zero measurement noise and writes to unused register indexes.
// Random tests then track noisy targets under several noise settings and
// idling mixes, and finish with a long output hold-off and then mixed idling.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = skf_pkg::DATA_WIDTH_DEF;
    localparam int GF = skf_pkg::GAIN_FRAC_BITS_DEF;
    localparam int LATENCY = 2 * GF + 5;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    localparam logic [skf_pkg::REG_INDEX_WIDTH-1:0] REG_UNUSED_2 =
        (skf_pkg::REG_INDEX_WIDTH)'(2);
    localparam logic [skf_pkg::REG_INDEX_WIDTH-1:0] REG_UNUSED_3 =
        (skf_pkg::REG_INDEX_WIDTH)'(3);

    localparam logic [63:0] DATA_MASK = (64'd1 << DW) - 64'd1;
    localparam logic [63:0] FRAC_ONE  = 64'd1 << GF;
    localparam logic [63:0] FRAC_MASK = FRAC_ONE - 64'd1;
    localparam longint EST_MIN = -(longint'(1) << (DW - 1));
    localparam longint EST_MAX = (longint'(1) << (DW - 1)) - 1;

    typedef struct packed {
        logic signed [DW-1:0] estimate;
        logic [GF-1:0]        gain;
    } t_filter_result;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic signed [DW-1:0]                i_measurement;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic signed [DW-1:0]                o_estimate;
    logic [GF-1:0]                       o_gain;
    logic                                i_cfg_we;
    logic [skf_pkg::REG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [skf_pkg::REG_WIDTH-1:0]       i_cfg_data;

    logic signed [DW-1:0]          filt_estimate;
    logic [DW-1:0]                 filt_variance;
    logic [skf_pkg::REG_WIDTH-1:0] noise_q;
    logic [skf_pkg::REG_WIDTH-1:0] noise_r;

    t_filter_result pending_results[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int holdoff_requests = 0;

    scalar_kalman_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_measurement (i_measurement),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_estimate    (o_estimate),
        .o_gain        (o_gain),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] frac_product(input logic [63:0] a, input logic [63:0] m,
                                                 input logic [63:0] bias);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = m * (a >> GF);
        lo = m * (a & FRAC_MASK) + bias;
        return hi + (lo >> GF);
    endfunction

    task automatic kalman_update(input logic [DW-1:0] meas);
        logic [63:0] pred;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] mag;
        logic [63:0] corr;
        longint diff;
        longint est_next;
        bit neg;
        t_filter_result res;
        pred = 64'(filt_variance) + 64'(noise_q);
        if (pred > DATA_MASK) pred = DATA_MASK;
        den = pred + 64'(noise_r);
        rem = pred;
        quo = '0;
        if (den != 0) begin
            for (int i = 0; i < GF; i++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    quo[0] = 1'b1;
                end
            end
        end
        quo = quo & FRAC_MASK;
        diff = longint'($signed(meas)) - longint'(filt_estimate);
        neg = diff < 0;
        mag = neg ? 64'(-diff) : 64'(diff);
        corr = frac_product(mag, quo, FRAC_ONE >> 1);
        est_next = neg ? longint'(filt_estimate) - longint'(corr)
                       : longint'(filt_estimate) + longint'(corr);
        if (est_next < EST_MIN) est_next = EST_MIN;
        if (est_next > EST_MAX) est_next = EST_MAX;
        filt_estimate = DW'(est_next);
        filt_variance = DW'(frac_product(pred, FRAC_ONE - quo, 64'd0));
        res.estimate = DW'(est_next);
        res.gain = GF'(quo);
        pending_results.push_back(res);
    endtask

    task automatic send_measurement(input logic [DW-1:0] meas);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_measurement <= meas;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        kalman_update(meas);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_register(input logic [skf_pkg::REG_INDEX_WIDTH-1:0] idx,
                                  input logic [skf_pkg::REG_WIDTH-1:0] value);
        wait_results_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            skf_pkg::REG_PROCESS_NOISE: begin
                noise_q = value;
                filt_estimate = '0;
                filt_variance = '0;
            end
            skf_pkg::REG_MEASUREMENT_NOISE: begin
                noise_r = value;
                filt_estimate = '0;
                filt_variance = '0;
            end
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_noise(input logic [skf_pkg::REG_WIDTH-1:0] q,
                             input logic [skf_pkg::REG_WIDTH-1:0] r);
        write_register(skf_pkg::REG_PROCESS_NOISE, q);
        write_register(skf_pkg::REG_MEASUREMENT_NOISE, r);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct <= recv_pct;
    endtask

    function automatic logic [skf_pkg::REG_WIDTH-1:0] pick_noise(
        input logic [skf_pkg::REG_WIDTH-1:0] lowest);
        logic [skf_pkg::REG_WIDTH-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom_range(4 * 65536);
            1: v = $urandom;
            2: v = (skf_pkg::REG_WIDTH)'(1) << $urandom_range(skf_pkg::REG_WIDTH - 1);
            default: v = $urandom_range(1) ? '1 : lowest;
        endcase
        if (v < lowest) v = lowest;
        return v;
    endfunction

    function automatic logic [DW-1:0] pick_measurement(input logic [DW-1:0] centre);
        case ($urandom_range(9))
            0: return $urandom;
            1: begin
                case ($urandom_range(3))
                    0: return {1'b0, {(DW - 1){1'b1}}};
                    1: return {1'b1, {(DW - 1){1'b0}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return centre + DW'($urandom_range(8 * 65536)) - DW'(4 * 65536);
        endcase
    endfunction

    task automatic test_reset_values();
        send_measurement(32'h0001_0000);
        send_measurement(32'h0001_0000);
        send_measurement(32'h0001_0000);
        send_measurement(32'h0000_0000);
    endtask

    task automatic test_measurement_extremes();
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h8000_0000);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h0000_0000);
        send_measurement(32'hFFFF_FFFF);
        send_measurement(32'h0000_0001);
    endtask

    task automatic test_gain_extremes();
        set_noise(32'hFFFF_FFFF, 32'h0000_0001);
        send_measurement(32'h8000_0000);
        send_measurement(32'h7FFF_FFFF);
        set_noise(32'h0000_0000, 32'hFFFF_FFFF);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h8000_0000);
    endtask

    task automatic test_zero_measurement_noise();
        set_noise(32'h0000_0000, 32'h0000_0000);
        send_measurement(32'h0004_0000);
        set_noise(32'h0001_0000, 32'h0000_0000);
        send_measurement(32'h0004_0000);
        send_measurement(32'hFFF0_0000);
    endtask

    task automatic test_unused_register_index();
        set_noise(skf_pkg::NOISE_RESET, skf_pkg::NOISE_RESET);
        send_measurement(32'h0010_0000);
        write_register(REG_UNUSED_2, 32'hFFFF_FFFF);
        write_register(REG_UNUSED_3, 32'h0000_0000);
        send_measurement(32'h0010_0000);
    endtask

    task automatic test_random_tracking();
        int send_idle[4];
        int recv_stall[4];
        logic [DW-1:0] centre;
        send_idle = '{0, 48, 0, 25};
        recv_stall = '{0, 0, 48, 25};
        for (int p = 0; p < 4; p++) begin
            set_idling(send_idle[p], recv_stall[p]);
            for (int s = 0; s < 3; s++) begin
                set_noise(pick_noise('0), pick_noise((skf_pkg::REG_WIDTH)'(1)));
                for (int n = 0; n < 105; n++) begin
                    if (n % 35 == 0) begin
                        centre = $urandom_range(1) ? DW'($urandom)
                                                   : DW'($urandom_range(64 * 65536));
                    end
                    send_measurement(pick_measurement(centre));
                end
            end
        end
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        set_noise(32'h0000_4000, 32'h0002_0000);
        holdoff_requests <= holdoff_requests + 1;
        for (int n = 0; n < 30; n++) send_measurement(pick_measurement(32'h0020_0000));
        wait_results_drained();
        set_idling(25, 25);
        for (int n = 0; n < 30; n++) send_measurement(pick_measurement(32'hFFE0_0000));
        wait_results_drained();
    endtask

    initial begin : result_sink
        int hold_count;
        int served;
        hold_count = 0;
        served = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (served != holdoff_requests) begin
                served++;
                hold_count = HOLDOFF_CYCLES;
            end
            if (hold_count > 0) begin
                hold_count--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_filter_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: estimate %h gain %h", o_estimate, o_gain);
                end
            end else begin
                exp_res = pending_results.pop_front();
                if (o_estimate !== exp_res.estimate || o_gain !== exp_res.gain) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: estimate exp %h got %h, gain exp %h got %h",
                                 exp_res.estimate, o_estimate, exp_res.gain, o_gain);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("tb_scalar_kalman_filter failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_measurement = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        filt_estimate = '0;
        filt_variance = '0;
        noise_q = skf_pkg::NOISE_RESET;
        noise_r = skf_pkg::NOISE_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_measurement_extremes();
        test_gain_extremes();
        test_zero_measurement_noise();
        test_unused_register_index();
        test_random_tracking();
        test_backpressure();
        wait_results_drained();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_scalar_kalman_filter passed");
        end else begin
            $display("tb_scalar_kalman_filter failed");
        end
        $finish;
    end

endmodule
